@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while reset is low
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while reset is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jczc_pkg.sv @@
`default_nettype none

package jczc_pkg;

    localparam int DEF_HYST_DEG  = 3;
    localparam int DEF_TEMP_BITS = 8;

    // bits set aside for the reset threshold values, sign included
    localparam int THR_RST_BITS = 8;

    localparam int FCC_W  = 14;
    localparam int CV_W   = 13;
    localparam int TERM_W = 10;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        ZONE_HOT       = 3'd0,
        ZONE_WARM      = 3'd1,
        ZONE_NORMAL    = 3'd2,
        ZONE_COOL      = 3'd3,
        ZONE_CHILLY    = 3'd4,
        ZONE_COLD      = 3'd5,
        ZONE_VERY_COLD = 3'd6,
        ZONE_FREEZING  = 3'd7
    } zone_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_STOP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARM         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHILLY       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEZE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_MODE = 3'd7;

    localparam int NUM_THR = 7;

    // threshold reset values, degrees C
    localparam int RST_HOT_STOP   = 60;
    localparam int RST_WARM       = 45;
    localparam int RST_NORMAL_LOW = 15;
    localparam int RST_COOL       = 10;
    localparam int RST_CHILLY     = 5;
    localparam int RST_COLD       = 0;
    localparam int RST_FREEZE     = -10;

    localparam logic [CV_W-1:0]   CV_FFC_ALT      = 13'd4470;
    localparam logic [CV_W-1:0]   CV_FFC_STD      = 13'd4480;
    localparam logic [CV_W-1:0]   CV_PUMP         = 13'd4608;
    localparam logic [TERM_W-1:0] TERM_HOT_KIND01 = 10'd833;
    localparam logic [TERM_W-1:0] TERM_HOT_OTHER  = 10'd784;
    localparam logic [TERM_W-1:0] TERM_PPS_COOL   = 10'd768;
    localparam logic [TERM_W-1:0] TERM_DEFAULT    = 10'd256;
    localparam int                TERM_HOT_TEMP   = 35;

    localparam logic [1:0] PD_PPS_ACTIVE = 2'd2;

    // fast charge current per zone, mA
    function automatic logic [FCC_W-1:0] zone_fcc(input zone_t z);
        logic [FCC_W-1:0] r;
        case (z)
            ZONE_WARM:      r = 14'd3000;
            ZONE_NORMAL:    r = 14'd6000;
            ZONE_COOL:      r = 14'd2400;
            ZONE_CHILLY:    r = 14'd1200;
            ZONE_COLD:      r = 14'd800;
            ZONE_VERY_COLD: r = 14'd400;
            default:        r = 14'd0;
        endcase
        return r;
    endfunction

    // constant-voltage target per zone, mV
    function automatic logic [CV_W-1:0] zone_cv(input zone_t z);
        logic [CV_W-1:0] r;
        case (z)
            ZONE_NORMAL, ZONE_COOL, ZONE_CHILLY, ZONE_COLD: r = 13'd4450;
            ZONE_VERY_COLD:                                 r = 13'd4200;
            default:                                        r = 13'd4100;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/jeita_charge_zone_controller.sv @@
`default_nettype none

// Battery temperature charge zone controller. Each input beat carries one
// temperature sample with charger status; each sample yields exactly one
// result beat giving the zone (hot, warm, normal, cool, chilly, cold, very
// cold, freezing), the charge enable, the held fast-charge current limit,
// the charge voltage target, the fast-charge decision, the termination
// current and a one-beat resume pulse when charging comes back after a stop.
// Moves back toward normal need the sample to pass the boundary by HYST_DEG
// degrees. Thresholds and the feature mode are written through the cfg
// port; the user must do so only while the block is idle, which the block
// does not enforce. Thresholds are TEMP_BITS wide, sign extended on write.
// Throughput is one beat per clock while m_ready holds high: the zone update
// reads and writes the zone state combinationally between the input register
// and the result register. A stalled result blocks the next input beat only
// once the input register holds a beat waiting for the result register.
module jeita_charge_zone_controller
    import jczc_pkg::*;
#(
    parameter int HYST_DEG  = DEF_HYST_DEG,
    parameter int TEMP_BITS = DEF_TEMP_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [TEMP_BITS-1:0]        cfg_wdata,

    // sample channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [TEMP_BITS-1:0] s_battery_temp,
    input  wire logic                        s_fast_charge_now,
    input  wire logic                        s_pump_active,
    input  wire logic [1:0]                  s_pd_status,
    input  wire logic [7:0]                  s_battery_kind,

    // result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [2:0]                       m_zone,
    output logic                             m_charge_enable,
    output logic [FCC_W-1:0]                 m_current_limit_ma,
    output logic [CV_W-1:0]                  m_charge_voltage_mv,
    output logic                             m_fast_charge_on,
    output logic [TERM_W-1:0]                m_term_current_ma,
    output logic                             m_term_current_valid,
    output logic                             m_resume_pulse
);

    // compare width: covers the widest threshold or sample plus the hysteresis offset
    localparam int CMP_W = ((TEMP_BITS > THR_RST_BITS) ? TEMP_BITS : THR_RST_BITS) + 2;

    localparam logic signed [CMP_W-1:0] HYST     = CMP_W'(HYST_DEG);
    localparam logic signed [CMP_W-1:0] HOT_TERM = CMP_W'(TERM_HOT_TEMP);

    // configuration
    logic signed [CMP_W-1:0] thr_reg [NUM_THR];
    logic [1:0]              feature_reg;

    // input stage
    logic                        in_valid_reg;
    logic signed [TEMP_BITS-1:0] in_temp_reg;
    logic                        in_fc_reg;
    logic                        in_pump_reg;
    logic [1:0]                  in_pd_reg;
    logic [7:0]                  in_kind_reg;

    // controller state
    zone_t              zone_reg, zone_next;
    logic [FCC_W-1:0]   held_reg, held_next;
    logic               resume_reg, resume_next;

    // result stage
    logic               out_valid_reg;
    zone_t              out_zone_reg;
    logic               out_chg_reg;
    logic [FCC_W-1:0]   out_fcc_reg;
    logic [CV_W-1:0]    out_cv_reg;
    logic               out_fc_reg;
    logic [TERM_W-1:0]  out_term_reg;
    logic               out_tvalid_reg;
    logic               out_pulse_reg;

    // per-beat combinational results
    logic signed [CMP_W-1:0] t;
    logic signed [CMP_W-1:0] t_hot, t_warm, t_norm, t_cool, t_chilly, t_cold, t_frz;
    logic               chg;
    logic               pulse;
    logic               fc;
    logic [CV_W-1:0]    cv;
    logic [TERM_W-1:0]  term;
    logic               tvalid;
    logic               ffc_en, alt;
    logic               advance;

    // input stage moves into the result stage when the result slot is free or being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign ffc_en = feature_reg[0];
    assign alt    = feature_reg[1];

    assign t        = {{(CMP_W-TEMP_BITS){in_temp_reg[TEMP_BITS-1]}}, in_temp_reg};
    assign t_hot    = thr_reg[CFG_HOT_STOP];
    assign t_warm   = thr_reg[CFG_WARM];
    assign t_norm   = thr_reg[CFG_NORMAL_LOW];
    assign t_cool   = thr_reg[CFG_COOL];
    assign t_chilly = thr_reg[CFG_CHILLY];
    assign t_cold   = thr_reg[CFG_COLD];
    assign t_frz    = thr_reg[CFG_FREEZE];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg[CFG_HOT_STOP]   <= CMP_W'(RST_HOT_STOP);
            thr_reg[CFG_WARM]       <= CMP_W'(RST_WARM);
            thr_reg[CFG_NORMAL_LOW] <= CMP_W'(RST_NORMAL_LOW);
            thr_reg[CFG_COOL]       <= CMP_W'(RST_COOL);
            thr_reg[CFG_CHILLY]     <= CMP_W'(RST_CHILLY);
            thr_reg[CFG_COLD]       <= CMP_W'(RST_COLD);
            thr_reg[CFG_FREEZE]     <= CMP_W'(RST_FREEZE);
            feature_reg             <= 2'b00;
        end else if (cfg_we) begin
            if (cfg_index == CFG_FEATURE_MODE) begin
                feature_reg <= cfg_wdata[1:0];
            end else begin
                // every other index is a threshold, stored sign extended
                thr_reg[cfg_index] <= {{(CMP_W-TEMP_BITS){cfg_wdata[TEMP_BITS-1]}}, cfg_wdata};
            end
        end
    end

    // zone decision with hysteresis and hold bands
    always_comb begin
        zone_next = zone_reg;
        chg       = 1'b1;
        if (t >= t_hot) begin
            zone_next = ZONE_HOT;
            chg       = 1'b0;
        end else if (t > t_warm) begin
            // just below hot stop: keep the zone, charging stays off
            if (t >= t_hot - HYST) begin
                chg = 1'b0;
            end else begin
                zone_next = ZONE_WARM;
            end
        end else if (t >= t_norm) begin
            if (!((zone_reg == ZONE_WARM && t >= t_warm - HYST) ||
                  (zone_reg == ZONE_COOL && t <= t_norm + HYST))) begin
                zone_next = ZONE_NORMAL;
            end
        end else if (t >= t_cool) begin
            if (!((zone_reg == ZONE_CHILLY || zone_reg == ZONE_COLD) &&
                  t <= t_cool + HYST)) begin
                zone_next = ZONE_COOL;
            end
        end else if (t >= t_chilly) begin
            if ((zone_reg == ZONE_COLD || zone_reg == ZONE_FREEZING ||
                 zone_reg == ZONE_VERY_COLD) && t <= t_chilly + HYST) begin
                if (zone_reg == ZONE_FREEZING) begin
                    chg = 1'b0;
                end
            end else begin
                zone_next = ZONE_CHILLY;
            end
        end else if (t >= t_cold) begin
            if ((zone_reg == ZONE_FREEZING || zone_reg == ZONE_VERY_COLD) &&
                t <= t_cold + HYST) begin
                if (zone_reg == ZONE_FREEZING) begin
                    chg = 1'b0;
                end
            end else begin
                zone_next = ZONE_COLD;
            end
        end else if (t >= t_frz) begin
            if (zone_reg == ZONE_FREEZING && t <= t_frz + HYST) begin
                chg = 1'b0;
            end else begin
                zone_next = ZONE_VERY_COLD;
            end
        end else begin
            zone_next = ZONE_FREEZING;
            chg       = 1'b0;
        end
    end

    // held current, voltage, fast charge, termination, resume
    always_comb begin
        // current limit only reloads on a real zone change into a charging zone
        held_next = held_reg;
        if (zone_next != zone_reg && zone_next != ZONE_HOT && zone_next != ZONE_FREEZING) begin
            held_next = zone_fcc(zone_next);
        end

        fc = ffc_en ? (zone_next == ZONE_NORMAL) : in_fc_reg;

        if (zone_next != ZONE_NORMAL) begin
            cv = zone_cv(zone_next);
        end else if (fc && ffc_en) begin
            cv = alt ? CV_FFC_ALT : CV_FFC_STD;
        end else begin
            cv = zone_cv(ZONE_NORMAL);
        end
        if (in_pump_reg && !alt) begin
            cv = CV_PUMP;
        end

        // alternate charger type has no termination control
        term   = '0;
        tvalid = 1'b0;
        if (!alt) begin
            tvalid = 1'b1;
            if (zone_next == ZONE_NORMAL && in_pd_reg == PD_PPS_ACTIVE) begin
                if (t >= HOT_TERM) begin
                    term = (in_kind_reg[7:1] == 7'd0) ? TERM_HOT_KIND01 : TERM_HOT_OTHER;
                end else begin
                    term = TERM_PPS_COOL;
                end
            end else begin
                term = TERM_DEFAULT;
            end
        end

        // remember a stop, pulse once on the first charging beat after it
        resume_next = resume_reg;
        pulse       = 1'b0;
        if (!chg) begin
            resume_next = 1'b1;
        end else if (resume_reg) begin
            pulse       = 1'b1;
            resume_next = 1'b0;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_temp_reg <= s_battery_temp;
            in_fc_reg   <= s_fast_charge_now;
            in_pump_reg <= s_pump_active;
            in_pd_reg   <= s_pd_status;
            in_kind_reg <= s_battery_kind;
        end
    end

    // controller state commits as the beat moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg   <= ZONE_NORMAL;
            held_reg   <= zone_fcc(ZONE_NORMAL);
            resume_reg <= 1'b0;
        end else if (advance) begin
            zone_reg   <= zone_next;
            held_reg   <= held_next;
            resume_reg <= resume_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_zone_reg   <= zone_next;
            out_chg_reg    <= chg;
            out_fcc_reg    <= held_next;
            out_cv_reg     <= cv;
            out_fc_reg     <= fc;
            out_term_reg   <= term;
            out_tvalid_reg <= tvalid;
            out_pulse_reg  <= pulse;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_zone               = out_zone_reg;
    assign m_charge_enable      = out_chg_reg;
    assign m_current_limit_ma   = out_fcc_reg;
    assign m_charge_voltage_mv  = out_cv_reg;
    assign m_fast_charge_on     = out_fc_reg;
    assign m_term_current_ma    = out_term_reg;
    assign m_term_current_valid = out_tvalid_reg;
    assign m_resume_pulse       = out_pulse_reg;

endmodule

`default_nettype wire

@@ rtl/jczc_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module jczc_checker
    import jczc_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [2:0]        m_zone,
    input wire logic              m_charge_enable,
    input wire logic [TERM_W-1:0] m_term_current_ma,
    input wire logic              m_term_current_valid,
    input wire logic              m_resume_pulse
);

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_zone), "result beat dropped or changed while stalled")

    // hot and freezing zones never charge
    `ASSERT_SAME(a_stop_zones, m_valid && (m_zone == ZONE_HOT || m_zone == ZONE_FREEZING), !m_charge_enable, "charging enabled in a stop zone")

    // a resume pulse only comes with charging on
    `ASSERT_SAME(a_resume_chg, m_valid && m_resume_pulse, m_charge_enable, "resume pulse without charge enable")

    // termination current is zero when not valid
    `ASSERT_SAME(a_term_zero, m_valid && !m_term_current_valid, m_term_current_ma == '0, "termination current set while not valid")

endmodule

bind jeita_charge_zone_controller jczc_checker u_jczc_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_zone               (m_zone),
    .m_charge_enable      (m_charge_enable),
    .m_term_current_ma    (m_term_current_ma),
    .m_term_current_valid (m_term_current_valid),
    .m_resume_pulse       (m_resume_pulse)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import jczc_pkg::*;

    localparam int HYST        = DEF_HYST_DEG;
    localparam int TW          = DEF_TEMP_BITS;
    localparam int PHASE_ITEMS = 75;
    localparam int NUM_PHASES  = 10;
    localparam int LONG_STALL  = 120;   // cycles the result side holds off once
    localparam int TAIL_CYCLES = 10;    // settle time after the last result

    // one sample beat as it goes onto the wire
    typedef struct packed {
        logic signed [TW-1:0] temp;
        logic                 fc;
        logic                 pump;
        logic [1:0]           pd;
        logic [7:0]           kind;
    } sample_t;

    // what the block should say about one sample
    typedef struct packed {
        zone_t             zone;
        logic              chg;
        logic [FCC_W-1:0]  ilim;
        logic [CV_W-1:0]   cv;
        logic              fc_on;
        logic [TERM_W-1:0] term;
        logic              term_ok;
        logic              resume;
    } verdict_t;

    // every input known from time zero
    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index         = CFG_HOT_STOP;
    logic [TW-1:0]        cfg_wdata         = '0;
    logic                 s_valid           = 1'b0;
    logic signed [TW-1:0] s_battery_temp    = '0;
    logic                 s_fast_charge_now = 1'b0;
    logic                 s_pump_active     = 1'b0;
    logic [1:0]           s_pd_status       = '0;
    logic [7:0]           s_battery_kind    = '0;
    logic                 m_ready           = 1'b0;

    logic                 s_ready;
    logic                 m_valid;
    logic [2:0]           m_zone;
    logic                 m_charge_enable;
    logic [FCC_W-1:0]     m_current_limit_ma;
    logic [CV_W-1:0]      m_charge_voltage_mv;
    logic                 m_fast_charge_on;
    logic [TERM_W-1:0]    m_term_current_ma;
    logic                 m_term_current_valid;
    logic                 m_resume_pulse;

    jeita_charge_zone_controller i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_battery_temp       (s_battery_temp),
        .s_fast_charge_now    (s_fast_charge_now),
        .s_pump_active        (s_pump_active),
        .s_pd_status          (s_pd_status),
        .s_battery_kind       (s_battery_kind),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_zone               (m_zone),
        .m_charge_enable      (m_charge_enable),
        .m_current_limit_ma   (m_current_limit_ma),
        .m_charge_voltage_mv  (m_charge_voltage_mv),
        .m_fast_charge_on     (m_fast_charge_on),
        .m_term_current_ma    (m_term_current_ma),
        .m_term_current_valid (m_term_current_valid),
        .m_resume_pulse       (m_resume_pulse)
    );

    // shadow copy of the zone tracker and its registers
    zone_t            zone_now;
    logic [FCC_W-1:0] held_ilim;
    bit               resume_due;
    int               thr_deg [NUM_THR];
    logic [1:0]       fmode;

    // threshold plan for the next register programming
    int               plan_thr [NUM_THR];

    sample_t          samples_to_send [$];
    verdict_t         expected_verdicts [$];
    sample_t          beat_on_wire;

    int               errors    = 0;
    int               tx_gap    = 0;
    int               rx_hold   = 0;
    bit               idle_on   = 1'b1;   // random idling on both sides
    bit               stall_req = 1'b0;   // ask the result side for one long hold-off

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // zone update for one sample, advances the shadow state
    function automatic verdict_t next_zone_verdict(input sample_t beat);
        int       t, hot, warm, nlow, cool, chilly, cold, frz;
        zone_t    s, ns;
        logic     chg, fc_on;
        verdict_t v;
        t      = $signed(beat.temp);
        hot    = thr_deg[CFG_HOT_STOP];
        warm   = thr_deg[CFG_WARM];
        nlow   = thr_deg[CFG_NORMAL_LOW];
        cool   = thr_deg[CFG_COOL];
        chilly = thr_deg[CFG_CHILLY];
        cold   = thr_deg[CFG_COLD];
        frz    = thr_deg[CFG_FREEZE];
        s      = zone_now;
        ns     = s;
        chg    = 1'b1;

        // fixed priority, hot side first; hysteresis only on the way back
        if (t >= hot) begin
            ns  = ZONE_HOT;
            chg = 1'b0;
        end else if (t > warm) begin
            // band just under hot stop keeps the old zone with charging off
            if (t >= hot - HYST) chg = 1'b0;
            else ns = ZONE_WARM;
        end else if (t >= nlow) begin
            if (!((s == ZONE_WARM && t >= warm - HYST) ||
                  (s == ZONE_COOL && t <= nlow + HYST)))
                ns = ZONE_NORMAL;
        end else if (t >= cool) begin
            if (!((s == ZONE_CHILLY || s == ZONE_COLD) && t <= cool + HYST))
                ns = ZONE_COOL;
        end else if (t >= chilly) begin
            if ((s == ZONE_COLD || s == ZONE_FREEZING || s == ZONE_VERY_COLD) &&
                t <= chilly + HYST) begin
                if (s == ZONE_FREEZING) chg = 1'b0;
            end else begin
                ns = ZONE_CHILLY;
            end
        end else if (t >= cold) begin
            if ((s == ZONE_FREEZING || s == ZONE_VERY_COLD) && t <= cold + HYST) begin
                if (s == ZONE_FREEZING) chg = 1'b0;
            end else begin
                ns = ZONE_COLD;
            end
        end else if (t >= frz) begin
            if (s == ZONE_FREEZING && t <= frz + HYST) chg = 1'b0;
            else ns = ZONE_VERY_COLD;
        end else begin
            ns  = ZONE_FREEZING;
            chg = 1'b0;
        end

        // current limit only moves on a real zone change, never into hot or freezing
        if (ns != s && ns != ZONE_HOT && ns != ZONE_FREEZING) begin
            case (ns)
                ZONE_WARM:   held_ilim = 14'd3000;
                ZONE_NORMAL: held_ilim = 14'd6000;
                ZONE_COOL:   held_ilim = 14'd2400;
                ZONE_CHILLY: held_ilim = 14'd1200;
                ZONE_COLD:   held_ilim = 14'd800;
                default:     held_ilim = 14'd400;
            endcase
        end
        zone_now = ns;

        fc_on = fmode[0] ? (ns == ZONE_NORMAL) : beat.fc;

        case (ns)
            ZONE_NORMAL: begin
                if (fc_on && fmode[0]) v.cv = fmode[1] ? CV_FFC_ALT : CV_FFC_STD;
                else v.cv = 13'd4450;
            end
            ZONE_COOL, ZONE_CHILLY, ZONE_COLD: v.cv = 13'd4450;
            ZONE_VERY_COLD:                    v.cv = 13'd4200;
            default:                           v.cv = 13'd4100;
        endcase
        if (beat.pump && !fmode[1]) v.cv = CV_PUMP;

        // alternate charger type has no term control
        if (fmode[1]) begin
            v.term    = '0;
            v.term_ok = 1'b0;
        end else begin
            v.term_ok = 1'b1;
            if (ns == ZONE_NORMAL && beat.pd == PD_PPS_ACTIVE) begin
                if (t >= TERM_HOT_TEMP)
                    v.term = (beat.kind <= 8'd1) ? TERM_HOT_KIND01 : TERM_HOT_OTHER;
                else
                    v.term = TERM_PPS_COOL;
            end else begin
                v.term = TERM_DEFAULT;
            end
        end

        // one-beat pulse on the first charging sample after any stop
        v.resume = 1'b0;
        if (!chg) begin
            resume_due = 1'b1;
        end else if (resume_due) begin
            v.resume   = 1'b1;
            resume_due = 1'b0;
        end

        v.zone  = ns;
        v.chg   = chg;
        v.ilim  = held_ilim;
        v.fc_on = fc_on;
        return v;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic queue_sample(input int temp, input bit fc, input bit pump,
                                input int pd, input int kind);
        sample_t beat;
        beat.temp = temp[TW-1:0];
        beat.fc   = fc;
        beat.pump = pump;
        beat.pd   = pd[1:0];
        beat.kind = kind[7:0];
        samples_to_send.push_back(beat);
    endtask

    // program all registers from plan_thr plus the feature mode
    task automatic apply_setting(input logic [1:0] mode);
        logic [CFG_IDX_W-1:0] i;
        for (i = 0; i < NUM_THR; i++) begin
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_HOT_STOP + i;
            cfg_wdata <= plan_thr[i][TW-1:0];
            thr_deg[i] = plan_thr[i];
        end
        // junk in the upper data bits must not matter
        @(posedge aclk);
        cfg_index <= CFG_FEATURE_MODE;
        cfg_wdata <= {6'($urandom_range(0, 63)), mode};
        fmode = mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // nothing queued, nothing on the wire, nothing outstanding
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_valid || expected_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    // sample driver: predicts on accept, then offers the next beat or idles
    always @(posedge aclk) begin : drive_samples
        bit slot_free;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            slot_free = !s_valid || s_ready;
            if (s_valid && s_ready)
                expected_verdicts.push_back(next_zone_verdict(beat_on_wire));
            if (slot_free) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (samples_to_send.size() != 0) begin
                    beat_on_wire = samples_to_send.pop_front();
                    s_valid           <= 1'b1;
                    s_battery_temp    <= beat_on_wire.temp;
                    s_fast_charge_now <= beat_on_wire.fc;
                    s_pump_active     <= beat_on_wire.pump;
                    s_pd_status       <= beat_on_wire.pd;
                    s_battery_kind    <= beat_on_wire.kind;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        tx_gap = $urandom_range(1, 17);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side backpressure: random bursts plus one long hold-off on request
    always @(posedge aclk) begin : pace_results
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (stall_req) begin
            stall_req = 1'b0;
            rx_hold   = LONG_STALL - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker, oldest expectation first
    always @(posedge aclk) begin : check_results
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, zone %0d",
                         $time, m_zone);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                check_field("zone",               16'(want.zone),    16'(m_zone));
                check_field("charge_enable",      16'(want.chg),     16'(m_charge_enable));
                check_field("current_limit_ma",   16'(want.ilim),    16'(m_current_limit_ma));
                check_field("charge_voltage_mv",  16'(want.cv),      16'(m_charge_voltage_mv));
                check_field("fast_charge_on",     16'(want.fc_on),   16'(m_fast_charge_on));
                check_field("term_current_ma",    16'(want.term),    16'(m_term_current_ma));
                check_field("term_current_valid", 16'(want.term_ok),
                            16'(m_term_current_valid));
                check_field("resume_pulse",       16'(want.resume),  16'(m_resume_pulse));
            end
        end
    end

    initial begin : stimulus
        int   p, n, r, walk, step_dn;
        logic [CFG_IDX_W-1:0] i;
        logic [1:0] mode;

        // shadow state matches the block after reset
        thr_deg[CFG_HOT_STOP]   = RST_HOT_STOP;
        thr_deg[CFG_WARM]       = RST_WARM;
        thr_deg[CFG_NORMAL_LOW] = RST_NORMAL_LOW;
        thr_deg[CFG_COOL]       = RST_COOL;
        thr_deg[CFG_CHILLY]     = RST_CHILLY;
        thr_deg[CFG_COLD]       = RST_COLD;
        thr_deg[CFG_FREEZE]     = RST_FREEZE;
        fmode      = 2'b00;
        zone_now   = ZONE_NORMAL;
        held_ilim  = 14'd6000;
        resume_due = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed walk through every zone on reset thresholds
        queue_sample(25, 0, 0, 0, 0);       // normal
        queue_sample(127, 1, 1, 3, 255);    // hottest sample, pump on
        queue_sample(58, 0, 0, 0, 0);       // band under hot stop, charging stays off
        queue_sample(50, 1, 0, 1, 7);       // warm, resume pulse
        queue_sample(44, 0, 0, 0, 0);       // warm held by hysteresis
        queue_sample(41, 0, 0, 2, 3);       // back to normal
        queue_sample(38, 0, 0, 2, 0);       // pps, hot term, kind 0
        queue_sample(36, 1, 0, 2, 1);       // pps, hot term, kind 1
        queue_sample(35, 0, 0, 2, 200);     // pps, hot term, other kind
        queue_sample(20, 0, 0, 2, 0);       // pps, cool term
        queue_sample(15, 1, 1, 3, 1);       // pd 3 acts as no pps
        queue_sample(12, 0, 0, 0, 0);       // cool
        queue_sample(17, 0, 0, 0, 0);       // cool held
        queue_sample(19, 0, 0, 0, 0);       // normal
        queue_sample(8, 0, 0, 0, 0);        // chilly
        queue_sample(12, 0, 0, 0, 0);       // chilly held
        queue_sample(2, 0, 1, 0, 0);        // cold
        queue_sample(-128, 1, 0, 2, 0);     // coldest sample, freezing
        queue_sample(-8, 0, 0, 0, 0);       // freezing held, still off
        queue_sample(-6, 0, 0, 0, 0);       // very cold, resume pulse
        queue_sample(-3, 0, 0, 0, 0);       // very cold
        queue_sample(1, 0, 0, 0, 0);        // very cold held
        queue_sample(4, 0, 0, 0, 0);        // cold
        queue_sample(60, 0, 1, 2, 0);       // exactly at hot stop
        queue_sample(-11, 1, 1, 1, 128);    // just below freeze

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            repeat (4) @(posedge aclk);

            plan_thr[CFG_HOT_STOP]   = RST_HOT_STOP;
            plan_thr[CFG_WARM]       = RST_WARM;
            plan_thr[CFG_NORMAL_LOW] = RST_NORMAL_LOW;
            plan_thr[CFG_COOL]       = RST_COOL;
            plan_thr[CFG_CHILLY]     = RST_CHILLY;
            plan_thr[CFG_COLD]       = RST_COLD;
            plan_thr[CFG_FREEZE]     = RST_FREEZE;
            mode = 2'($urandom_range(0, 3));
            case (p)
                0, 1, 2: mode = 2'(p + 1);                       // each nonzero feature combo
                3: for (i = 0; i < NUM_THR; i++) plan_thr[i] = 127;
                4: for (i = 0; i < NUM_THR; i++) plan_thr[i] = -128;
                5: begin
                    plan_thr[CFG_HOT_STOP] = 127;
                    plan_thr[CFG_FREEZE]   = -128;
                end
                6, 8: begin
                    // ordered thresholds, ties allowed
                    walk = 127 - int'($urandom_range(0, 30));
                    for (i = 0; i < NUM_THR; i++) begin
                        plan_thr[i] = walk;
                        step_dn     = int'($urandom_range(0, 36));
                        walk        = (walk - step_dn < -128) ? -128 : walk - step_dn;
                    end
                end
                7: for (i = 0; i < NUM_THR; i++) plan_thr[i] = int'($urandom_range(0, 255)) - 128;
                default: mode = 2'b00;
            endcase
            apply_setting(mode);

            // no idling in the extreme-low phase and the last phase
            idle_on = (p != 4) && (p != NUM_PHASES - 1);
            if (p == 1) stall_req = 1'b1;

            walk = 25;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off until everything has come back
                if (p == 6 && n == PHASE_ITEMS / 2) wait_drained();
                r = int'($urandom_range(0, 99));
                if (r < 60)
                    walk = walk + int'($urandom_range(0, 8)) - 4;
                else if (r < 85)
                    walk = thr_deg[CFG_IDX_W'($urandom_range(0, NUM_THR - 1))] +
                           int'($urandom_range(0, 2 * HYST + 4)) - HYST - 2;
                else if (r < 95)
                    walk = int'($urandom_range(0, 255)) - 128;
                else
                    walk = r[0] ? 127 : -128;
                if (walk > 127) walk = 127;
                if (walk < -128) walk = -128;
                queue_sample(walk, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                             ($urandom_range(0, 9) == 0) ? 3 : int'($urandom_range(0, 2)),
                             ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1))
                                                        : int'($urandom_range(0, 255)));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/jczc_pkg.sv
rtl/jeita_charge_zone_controller.sv
rtl/jczc_checker.sv
tb/tb.sv
